[hw/rtl/spe_pkg.sv]
// Package for the shower plane energy estimator: types, constants, exp table.
// No dependencies.
package spe_pkg;

  localparam logic [30:0] Log2eQ30 = 31'd1549082005;
  localparam logic [55:0] SumMax = {56{1'b1}};
  localparam logic signed [47:0] EMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] EMin = 48'sh8000_0000_0000;
  localparam logic signed [47:0] BadEnergy = -48'sd65470464;
  localparam int unsigned NumRegs = 7;

  typedef enum logic [2:0] {
    REG_GRAD0 = 3'd0, REG_ICPT0 = 3'd1, REG_GRAD1 = 3'd2, REG_ICPT1 = 3'd3,
    REG_GRAD2 = 3'd4, REG_ICPT2 = 3'd5, REG_DECAY = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ARG, ST_EXP, ST_SCALE, ST_ACC, ST_EMIT, ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic do_arg;
    logic do_exp;
    logic do_scale;
    logic do_acc;
    logic do_emit;
    logic out_set;
  } spe_cmd_t;

  typedef struct packed {
    logic is_end;
  } spe_sts_t;

  // 2^(i/2^bits) in Q1.30, series evaluated at elaboration-style constant
  function automatic logic [31:0] frac_pow2(input int unsigned idx, input int unsigned bits);
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] sum;
    u = (64'(idx) * 64'd744261118) >> bits;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * u) >> 30) / 64'(n);
      sum = sum + term;
    end
    return sum[31:0];
  endfunction

endpackage

[hw/rtl/shower_plane_energy_estimator_unit.sv]
// Shower plane energy estimator: a hit passes through accept, argument multiply,
// log2e multiply and table read, charge scale and accumulate; an end command passes
// through accept, emit and the output register, and waits there while the output stalls.
// One item at a time; the next item is taken once the previous finishes.
// Reset (synchronous, active low) clears sums, counts, output valid and registers.
// Depends on spe_pkg, spe_ctrl, spe_dp.
module shower_plane_energy_estimator_unit import spe_pkg::*; #(
  parameter int unsigned NUM_PLANES = 3,
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [1:0]         in_plane,
  input  logic [23:0]        in_hit_charge,
  input  logic [15:0]        in_peak_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_energy_plane0,
  output logic signed [47:0] out_energy_plane1,
  output logic signed [47:0] out_energy_plane2,
  output logic [2:0]         out_valid_mask,
  output logic [1:0]         out_best_plane,
  output logic               out_best_valid
);
  spe_cmd_t cmd;
  spe_sts_t sts;

  spe_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_stall, .out_valid, .sts, .cmd
  );

  spe_dp #(.NUM_PLANES(NUM_PLANES), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_command, .in_plane, .in_hit_charge, .in_peak_time,
    .out_energy_plane0, .out_energy_plane1, .out_energy_plane2,
    .out_valid_mask, .out_best_plane, .out_best_valid
  );
endmodule

[hw/rtl/spe_ctrl.sv]
// Controller state machine for the energy estimator.
// Depends on spe_pkg.
module spe_ctrl import spe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_stall,
  output logic     out_valid,
  input  spe_sts_t sts,
  output spe_cmd_t cmd
);
  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_ARG;
        end
      end
      ST_ARG: begin
        if (sts.is_end) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.do_arg = 1'b1;
          state_nxt = ST_EXP;
        end
      end
      ST_EXP: begin
        cmd.do_exp = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.do_scale = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.do_acc = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        cmd.do_emit = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_set = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("input taken while busy");
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |=> state_r == ST_OUT)
    else $error("emit not followed by output");
`endif
endmodule

[hw/rtl/spe_dp.sv]
// Datapath: exponential correction, per-plane accumulation, energy and best plane.
// Depends on spe_pkg.
module spe_dp import spe_pkg::*; #(
  parameter int unsigned NUM_PLANES = 3,
  parameter int unsigned EXP_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spe_cmd_t           cmd,
  output spe_sts_t           sts,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_command,
  input  logic [1:0]         in_plane,
  input  logic [23:0]        in_hit_charge,
  input  logic [15:0]        in_peak_time,
  output logic signed [47:0] out_energy_plane0,
  output logic signed [47:0] out_energy_plane1,
  output logic signed [47:0] out_energy_plane2,
  output logic [2:0]         out_valid_mask,
  output logic [1:0]         out_best_plane,
  output logic               out_best_valid
);
  localparam int unsigned TabDepth = 1 << EXP_TABLE_BITS;

  logic [31:0] grad_r [3];
  logic [31:0] icpt_r [3];
  logic [31:0] decay_r;

  logic        cmd_r;
  logic [1:0]  plane_r;
  logic [23:0] charge_r;
  logic [15:0] ptime_r;
  logic [31:0] a_r;
  logic [31:0] tab_r;
  logic [8:0]  k_r;
  logic [55:0] corr_r;
  logic [55:0] sum_r [3];
  logic [15:0] cnt_r [3];
  logic signed [47:0] e_r [3];
  logic [2:0]  mask_r;
  logic [1:0]  best_r;
  logic        any_r;

  // exp table as constant logic
  logic [31:0] exp_tab [TabDepth];
  always_comb begin
    for (int i = 0; i < TabDepth; i++) exp_tab[i] = frac_pow2(i, EXP_TABLE_BITS);
  end

  assign sts.is_end = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < 3; p++) begin
        grad_r[p] <= 32'd65536;
        icpt_r[p] <= '0;
      end
      decay_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GRAD0: grad_r[0] <= cfg_wdata;
        REG_ICPT0: icpt_r[0] <= cfg_wdata;
        REG_GRAD1: grad_r[1] <= cfg_wdata;
        REG_ICPT1: icpt_r[1] <= cfg_wdata;
        REG_GRAD2: grad_r[2] <= cfg_wdata;
        REG_ICPT2: icpt_r[2] <= cfg_wdata;
        REG_DECAY: decay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // argument and exponent split
  logic [47:0] arg_prod;
  logic [39:0] a_full;
  logic [62:0] y_prod;
  logic [32:0] y_val;
  assign arg_prod = decay_r * ptime_r;
  assign a_full = arg_prod[47:8];
  assign y_prod = a_r * Log2eQ30;
  assign y_val = y_prod[62:30];

  // scaling
  logic [55:0] prod;
  logic [55:0] corr_val;
  logic [6:0]  s;
  assign prod = charge_r * tab_r;
  always_comb begin
    s = 7'(k_r - 9'd30);
    if (k_r <= 9'd30) corr_val = prod >> (9'd30 - k_r);
    else if (prod == '0) corr_val = '0;
    else if (k_r >= 9'd86 || (prod >> (7'd56 - s)) != '0) corr_val = SumMax;
    else corr_val = prod << s;
  end

  // accumulate
  logic [56:0] acc;
  assign acc = {1'b0, sum_r[plane_r]} + {1'b0, corr_r};

  // energy per plane
  logic signed [47:0] e_val [3];
  logic [2:0] ok;
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      logic signed [32:0] g;
      logic [31:0] mag;
      logic [59:0] hi;
      logic [59:0] pp;
      logic signed [57:0] v;
      g = {grad_r[p][31], grad_r[p]};
      mag = grad_r[p][31] ? 32'(-g) : grad_r[p];
      hi = 60'(sum_r[p][55:28]) * 60'(mag);
      pp = (hi << 28) + 60'(sum_r[p][27:0]) * 60'(mag);
      if (hi >= (60'd1 << 26)) begin
        v = grad_r[p][31] ? 58'(EMin) : 58'(EMax);
      end else begin
        v = grad_r[p][31] ? -58'((pp + 60'd15) >> 4) : 58'(pp >> 4);
        v = v + 58'(signed'(icpt_r[p]));
      end
      if (v > 58'(EMax)) e_val[p] = EMax;
      else if (v < 58'(EMin)) e_val[p] = EMin;
      else e_val[p] = v[47:0];
      ok[p] = (p < NUM_PLANES) && (cnt_r[p] != '0) && !e_val[p][47];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_command;
      plane_r <= in_plane;
      charge_r <= in_hit_charge;
      ptime_r <= in_peak_time;
    end
    if (cmd.do_arg) a_r <= (a_full > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : a_full[31:0];
    if (cmd.do_exp) begin
      k_r <= y_val[32:24];
      tab_r <= exp_tab[y_val[23:24-EXP_TABLE_BITS]];
    end
    if (cmd.do_scale) corr_r <= corr_val;
    if (cmd.do_emit) begin
      for (int p = 0; p < 3; p++) e_r[p] <= ok[p] ? e_val[p] : BadEnergy;
      mask_r <= ok;
      any_r <= |ok;
      if (ok[0] && !(ok[1] && cnt_r[1] > cnt_r[0]) && !(ok[2] && cnt_r[2] > cnt_r[0]))
        best_r <= 2'd0;
      else if (ok[1] && !(ok[2] && cnt_r[2] > cnt_r[1])) best_r <= 2'd1;
      else if (ok[2]) best_r <= 2'd2;
      else best_r <= 2'd0;
    end
    if (cmd.out_set) begin
      out_energy_plane0 <= e_r[0];
      out_energy_plane1 <= e_r[1];
      out_energy_plane2 <= e_r[2];
      out_valid_mask <= mask_r;
      out_best_plane <= best_r;
      out_best_valid <= any_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < 3; p++) begin
        sum_r[p] <= '0;
        cnt_r[p] <= '0;
      end
    end else if (cmd.do_emit) begin
      for (int p = 0; p < 3; p++) begin
        sum_r[p] <= '0;
        cnt_r[p] <= '0;
      end
    end else if (cmd.do_acc && 32'(plane_r) < NUM_PLANES && plane_r != 2'd3) begin
      sum_r[plane_r] <= acc[56] ? SumMax : acc[55:0];
      if (cnt_r[plane_r] != 16'hFFFF) cnt_r[plane_r] <= cnt_r[plane_r] + 16'd1;
    end
  end

`ifndef SYNTHESIS
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_emit |=> cnt_r[0] == '0 && cnt_r[1] == '0 && cnt_r[2] == '0)
    else $error("counts not cleared after emit");
  a_mask_best: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.do_emit) |-> any_r == (mask_r != '0))
    else $error("best_valid disagrees with mask");
  a_best_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.do_emit) && any_r |-> mask_r[best_r])
    else $error("best plane not valid");
`endif
endmodule
